/* design/snd_pkg.sv */
// Shared types, constants and arithmetic helpers for the sigmoid neuron block.
package snd_pkg;

   localparam int MAX_INPUTS  = 64;
   localparam int ADDR_W      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int INDEX_W     = 6;
   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int RATE_W      = 16;
   localparam int ACT_W       = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd6554;

   // Sigmoid breakpoints in Q16.16 and offsets in Q0.16
   localparam logic [31:0] SIG_KNEE_SAT  = 32'd327680;
   localparam logic [31:0] SIG_KNEE_HIGH = 32'd155648;
   localparam logic [31:0] SIG_KNEE_LOW  = 32'd65536;
   localparam logic [16:0] SIG_ONE       = 17'd65536;
   localparam logic [16:0] SIG_OFS_HIGH  = 17'd55296;
   localparam logic [16:0] SIG_OFS_MID   = 17'd40960;
   localparam logic [16:0] SIG_OFS_LOW   = 17'd32768;

   typedef enum logic [1:0] {
      CMD_PREDICT     = 2'd0,
      CMD_TRAIN       = 2'd1,
      CMD_LOAD_WEIGHT = 2'd2,
      CMD_LOAD_BIAS   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_BIAS,
      ST_CLIP,
      ST_OUT,
      ST_LE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [ADDR_W-1:0]   addr;
      logic                in_range;
      logic [DATA_W-1:0]   value;
      logic [DATA_W-1:0]   error_value;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [ACC_W-1:0] sum;
      logic             sat;
   } add_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } clip_type;

   function automatic add_type sat_add64(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
      logic [ACC_W:0] wide;
      add_type        res;
      wide = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (wide[ACC_W] != wide[ACC_W-1]) begin
         res.sat = 1'b1;
         res.sum = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         res.sat = 1'b0;
         res.sum = wide[ACC_W-1:0];
      end
      return res;
   endfunction

   function automatic clip_type clip32(logic [ACC_W-1:0] v);
      clip_type res;
      if (!v[ACC_W-1] && (v[ACC_W-2:DATA_W-1] != '0)) begin
         res.sat   = 1'b1;
         res.value = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[ACC_W-1] && (v[ACC_W-2:DATA_W-1] != '1)) begin
         res.sat   = 1'b1;
         res.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res.sat   = 1'b0;
         res.value = v[DATA_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [ACT_W-1:0] plan_sigmoid(logic [DATA_W-1:0] x);
      logic [DATA_W-1:0] a;
      logic [16:0]       y;
      logic [ACT_W-1:0]  res;
      a = x[DATA_W-1] ? (~x + 32'd1) : x;
      if (a >= SIG_KNEE_SAT) begin
         y = SIG_ONE;
      end else if (a >= SIG_KNEE_HIGH) begin
         y = 17'(a >> 5) + SIG_OFS_HIGH;
      end else if (a >= SIG_KNEE_LOW) begin
         y = 17'(a >> 3) + SIG_OFS_MID;
      end else begin
         y = 17'(a >> 2) + SIG_OFS_LOW;
      end
      if (x[DATA_W-1]) begin
         res = 16'(SIG_ONE - y);
      end else begin
         res = y[16] ? 16'hFFFF : y[15:0];
      end
      return res;
   endfunction

endpackage

/* design/snd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module snd_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/snd_front.sv */
// Front end: accepts request beats, classifies them and queues them for the back end.
module snd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [5:0]          req_index,
   input  logic signed [31:0]  req_value,
   input  logic signed [31:0]  req_error_value,
   input  logic                req_last,
   output logic                q_valid,
   output snd_pkg::item_type   q_item,
   input  logic                q_pop
);

   snd_pkg::item_type               entry_ff [snd_pkg::QUEUE_DEPTH];
   logic [snd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [snd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [snd_pkg::QCNT_W-1:0]      count_ff, count_in;
   snd_pkg::item_type               item;
   logic                            push;
   logic                            pop;

   // Classify: decode the command and check the index against the store size
   always_comb begin
      item.cmd         = snd_pkg::cmd_type'(req_cmd);
      item.addr        = snd_pkg::ADDR_W'(req_index);
      item.in_range    = (32'(req_index) < 32'(snd_pkg::MAX_INPUTS));
      item.value       = req_value;
      item.error_value = req_error_value;
      item.last        = req_last;
   end

   assign req_ready = (count_ff != snd_pkg::QCNT_W'(snd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && (count_ff != '0);
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == snd_pkg::QPTR_W'(snd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == snd_pkg::QPTR_W'(snd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* design/snd_back.sv */
// Back end: weight store, shared multiplier, accumulator, trainer and sigmoid output.
module snd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         learning_rate,
   input  logic                q_valid,
   input  snd_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_activation_out,
   output logic                rsp_sum_saturated
);

   snd_pkg::state_type         state_ff, state_in;
   snd_pkg::item_type          item_ff, item_in;
   logic [63:0]                acc_ff, acc_in;
   logic                       sat_ff, sat_in;
   logic [31:0]                bias_ff, bias_in;
   logic [63:0]                prod_ff, prod_in;
   logic [31:0]                le_ff, le_in;
   logic [63:0]                sum_ff, sum_in;
   logic                       sum_sat_ff, sum_sat_in;
   logic [31:0]                x_ff, x_in;
   logic                       x_sat_ff, x_sat_in;
   logic                       out_valid_ff, out_valid_in;
   logic [15:0]                out_act_ff, out_act_in;
   logic                       out_sat_ff, out_sat_in;

   logic signed [31:0]         mul_a, mul_b;
   logic signed [63:0]         mul_p;
   logic [31:0]                weight;
   logic [63:0]                delta;
   snd_pkg::add_type           add_res;
   snd_pkg::clip_type          clip_res;
   snd_pkg::clip_type          bias_res;

   logic                       ram_wr_en;
   logic [snd_pkg::ADDR_W-1:0] ram_wr_addr;
   logic [31:0]                ram_wr_data;
   logic                       ram_rd_en;
   logic [31:0]                ram_rd_data;

   snd_ram #(
      .WIDTH  (snd_pkg::DATA_W),
      .DEPTH  (snd_pkg::MAX_INPUTS),
      .ADDR_W (snd_pkg::ADDR_W)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (q_item.addr),
      .rd_data (ram_rd_data)
   );

   assign mul_p  = mul_a * mul_b;
   assign weight = item_ff.in_range ? ram_rd_data : '0;
   // Q32.32 product back to Q16.16 step with floor
   assign delta  = $signed(prod_ff) >>> 16;

   assign rsp_valid          = out_valid_ff;
   assign rsp_activation_out = out_act_ff;
   assign rsp_sum_saturated  = out_sat_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      bias_in      = bias_ff;
      prod_in      = prod_ff;
      le_in        = le_ff;
      sum_in       = sum_ff;
      sum_sat_in   = sum_sat_ff;
      x_in         = x_ff;
      x_sat_in     = x_sat_ff;
      out_valid_in = out_valid_ff;
      out_act_in   = out_act_ff;
      out_sat_in   = out_sat_ff;
      q_pop        = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = item_ff.addr;
      ram_wr_data  = item_ff.value;
      mul_a        = '0;
      mul_b        = '0;
      add_res      = '0;
      clip_res     = '0;
      bias_res     = '0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         snd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               case (q_item.cmd)
                  snd_pkg::CMD_PREDICT: begin
                     ram_rd_en = 1'b1;
                     state_in  = snd_pkg::ST_MUL;
                  end
                  snd_pkg::CMD_TRAIN: begin
                     ram_rd_en = 1'b1;
                     state_in  = snd_pkg::ST_LE;
                  end
                  snd_pkg::CMD_LOAD_WEIGHT: begin
                     ram_wr_en   = q_item.in_range;
                     ram_wr_addr = q_item.addr;
                     ram_wr_data = q_item.value;
                  end
                  snd_pkg::CMD_LOAD_BIAS: begin
                     bias_in = q_item.value;
                  end
                  default: begin
                     state_in = snd_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         snd_pkg::ST_MUL: begin
            mul_a    = $signed(weight);
            mul_b    = $signed(item_ff.value);
            prod_in  = mul_p;
            state_in = snd_pkg::ST_ACC;
         end
         snd_pkg::ST_ACC: begin
            add_res  = snd_pkg::sat_add64(acc_ff, prod_ff);
            acc_in   = add_res.sum;
            sat_in   = sat_ff | add_res.sat;
            state_in = item_ff.last ? snd_pkg::ST_BIAS : snd_pkg::ST_IDLE;
         end
         snd_pkg::ST_BIAS: begin
            add_res    = snd_pkg::sat_add64(acc_ff, {{16{bias_ff[31]}}, bias_ff, 16'd0});
            sum_in     = add_res.sum;
            sum_sat_in = sat_ff | add_res.sat;
            // Vector done: clear for the next one
            acc_in     = '0;
            sat_in     = 1'b0;
            state_in   = snd_pkg::ST_CLIP;
         end
         snd_pkg::ST_CLIP: begin
            clip_res = snd_pkg::clip32(64'($signed(sum_ff) >>> 16));
            x_in     = clip_res.value;
            x_sat_in = sum_sat_ff | clip_res.sat;
            state_in = snd_pkg::ST_OUT;
         end
         snd_pkg::ST_OUT: begin
            // Hold until the output register is free
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_act_in   = snd_pkg::plan_sigmoid(x_ff);
               out_sat_in   = x_sat_ff;
               state_in     = snd_pkg::ST_IDLE;
            end
         end
         snd_pkg::ST_LE: begin
            // le = floor(rate * error / 2^16), always fits 32 bits
            mul_a    = $signed({16'd0, learning_rate});
            mul_b    = $signed(item_ff.error_value);
            le_in    = mul_p[47:16];
            state_in = snd_pkg::ST_UPDATE;
            if (item_ff.in_range) begin
               state_in = snd_pkg::ST_UPDATE;
            end
         end
         snd_pkg::ST_UPDATE: begin
            // First pass: form le * value; second pass writes the updated weight
            mul_a    = $signed(le_ff);
            mul_b    = $signed(item_ff.value);
            prod_in  = mul_p;
            state_in = snd_pkg::ST_ACC;
            item_in.cmd = snd_pkg::CMD_TRAIN;
            if (item_ff.cmd == snd_pkg::CMD_TRAIN) begin
               item_in.cmd = snd_pkg::CMD_LOAD_WEIGHT;
               state_in    = snd_pkg::ST_UPDATE;
            end
            if (item_ff.cmd == snd_pkg::CMD_LOAD_WEIGHT) begin
               prod_in     = prod_ff;
               clip_res    = snd_pkg::clip32({{32{ram_rd_data[31]}}, ram_rd_data} + delta);
               ram_wr_en   = item_ff.in_range;
               ram_wr_data = clip_res.value;
               if (item_ff.last) begin
                  bias_res = snd_pkg::clip32({{32{bias_ff[31]}}, bias_ff}
                                             + {{32{le_ff[31]}}, le_ff});
                  bias_in  = bias_res.value;
               end
               state_in = snd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = snd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= snd_pkg::ST_IDLE;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         bias_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         bias_ff      <= bias_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      prod_ff    <= prod_in;
      le_ff      <= le_in;
      sum_ff     <= sum_in;
      sum_sat_ff <= sum_sat_in;
      x_ff       <= x_in;
      x_sat_ff   <= x_sat_in;
      out_act_ff <= out_act_in;
      out_sat_ff <= out_sat_in;
   end

endmodule

/* design/sigmoid_neuron_delta_rule.sv */
// Top level of the sigmoid neuron with delta-rule training: CSR register, front and back ends.
//
//   port group  direction  handshake              payload
//   req_*       in         req_valid / req_ready  cmd, index, value, error_value, last
//   rsp_*       out        rsp_valid / rsp_ready  activation_out, sum_saturated
//   csr_*       in         csr_wr_en              csr_wr_data (learning rate, Q0.16)
//
// The back end runs one item at a time around a shared 32x32 multiplier and the weight RAM:
// predict: multiply, accumulate, on last bias, clip, out; train: scale error, multiply, write.
// A two-beat queue in front takes beats while the back end works; req_ready drops when full.
// A result waits in the output register; a stalled rsp side only holds a last-predict beat.
// Reset is synchronous: it clears the queue, bias and accumulator and reloads the rate;
// weights stay undefined.
module sigmoid_neuron_delta_rule (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [5:0]          req_index,
   input  logic signed [31:0]  req_value,
   input  logic signed [31:0]  req_error_value,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_activation_out,
   output logic                rsp_sum_saturated,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   logic [15:0]       rate_ff, rate_in;
   logic              q_valid;
   snd_pkg::item_type q_item;
   logic              q_pop;

   assign rate_in = csr_wr_en ? csr_wr_data : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= snd_pkg::RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   snd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_index       (req_index),
      .req_value       (req_value),
      .req_error_value (req_error_value),
      .req_last        (req_last),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   snd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .learning_rate      (rate_ff),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_activation_out (rsp_activation_out),
      .rsp_sum_saturated  (rsp_sum_saturated)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sigmoid neuron with delta-rule training.
`timescale 1ns / 1ps

module testbench;

   localparam int   SEGMENTS     = 10;
   localparam int   SEG_BEATS    = 140;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   LIMIT_CYCLES = 400000;
   localparam int   DIR_ROWS     = 25;
   localparam longint Q_MAX      = 64'sd2147483647;
   localparam longint Q_MIN      = -64'sd2147483648;

   typedef struct packed {
      logic [15:0] act;
      logic        sat;
   } activation_type;

   typedef struct packed {
      snd_pkg::cmd_type op;
      logic [5:0]       idx;
      logic [31:0]      val;
      logic [31:0]      err;
      logic             last;
      logic             typed;
      logic [15:0]      act;
      logic             sat;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = snd_pkg::CMD_PREDICT;
   logic [5:0]  req_index = '0;
   logic [31:0] req_value = '0;
   logic [31:0] req_error_value = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_activation_out;
   logic        rsp_sum_saturated;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // neuron state as the block should hold it
   longint      weight_q [64];
   bit          weight_written [64];
   longint      bias_q = 0;
   longint      acc_q = 0;
   bit          acc_sat = 1'b0;
   logic [15:0] rate_q = snd_pkg::RATE_RESET;

   activation_type pending_activations [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          beats_sent = 0;
   int          activations_checked = 0;
   int          saturated_seen = 0;
   int          rate_writes = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   dir_row_type dir_rows [DIR_ROWS];

   sigmoid_neuron_delta_rule DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_index          (req_index),
      .req_value          (req_value),
      .req_error_value    (req_error_value),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_activation_out (rsp_activation_out),
      .rsp_sum_saturated  (rsp_sum_saturated),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint add_sat64(longint a, longint b, inout bit sat);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat = 1'b1;
         s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic longint clip_to32(longint v, inout bit sat);
      if (v > Q_MAX) begin
         sat = 1'b1;
         return Q_MAX;
      end
      if (v < Q_MIN) begin
         sat = 1'b1;
         return Q_MIN;
      end
      return v;
   endfunction

   // piecewise-linear sigmoid, Q16.16 in, Q0.16 out
   function automatic logic [15:0] sigmoid_q16(longint x);
      longint a;
      longint y;
      a = (x < 0) ? -x : x;
      if (a >= 327680)
         y = 65536;
      else if (a >= 155648)
         y = (a >>> 5) + 55296;
      else if (a >= 65536)
         y = (a >>> 3) + 40960;
      else
         y = (a >>> 2) + 32768;
      if (x < 0)
         return 16'(65536 - y);
      return (y > 65535) ? 16'hFFFF : 16'(y);
   endfunction

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return 32'(int'($urandom_range(524288)) - 262144);
         5: return 32'(int'($urandom_range(65536)) - 32768);
         6, 7: return $urandom;
         8: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return 32'(int'($urandom_range(2097152)) - 1048576);
      endcase
   endfunction

   task automatic neuron_step(input snd_pkg::cmd_type op, input logic [5:0] idx,
                              input logic signed [31:0] v, input logic signed [31:0] e,
                              input logic l, output bit fired, output activation_type res);
      longint s;
      longint le;
      longint d;
      bit     sat;
      bit     spill;
      fired = 1'b0;
      res   = '0;
      spill = 1'b0;
      case (op)
         snd_pkg::CMD_PREDICT: begin
            acc_q = add_sat64(acc_q, weight_q[idx] * longint'(v), acc_sat);
            if (l) begin
               sat = acc_sat;
               s = add_sat64(acc_q, bias_q * 65536, sat);
               s = clip_to32(s >>> 16, sat);
               res.act = sigmoid_q16(s);
               res.sat = sat;
               fired   = 1'b1;
               acc_q   = 0;
               acc_sat = 1'b0;
            end
         end
         snd_pkg::CMD_TRAIN: begin
            le = (longint'(rate_q) * longint'(e)) >>> 16;
            d  = (le * longint'(v)) >>> 16;
            weight_q[idx] = clip_to32(weight_q[idx] + d, spill);
            if (l)
               bias_q = clip_to32(bias_q + le, spill);
         end
         snd_pkg::CMD_LOAD_WEIGHT: begin
            weight_q[idx]       = longint'(v);
            weight_written[idx] = 1'b1;
         end
         default: begin
            bias_q = longint'(v);
         end
      endcase
   endtask

   task automatic send_beat(input snd_pkg::cmd_type op, input logic [5:0] idx,
                            input logic [31:0] v, input logic [31:0] e, input logic l,
                            input bit typed = 1'b0, input activation_type typed_res = '0);
      bit             fired;
      activation_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= op;
      req_index       <= idx;
      req_value       <= v;
      req_error_value <= e;
      req_last        <= l;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      neuron_step(op, idx, v, e, l, fired, res);
      if (fired)
         pending_activations = {pending_activations, (typed ? typed_res : res)};
   endtask

   // hold the sender until the block has drained, then write the rate
   task automatic set_rate(input logic [15:0] r);
      req_valid <= 1'b0;
      while (pending_activations.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rate_q = r;
      rate_writes++;
   endtask

   // result side: check each accepted beat against the oldest expectation
   initial begin
      activation_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_activations.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat, actual act %h sat %b", $time,
                        rsp_activation_out, rsp_sum_saturated);
            end else begin
               want = pending_activations.pop_front();
               activations_checked++;
               if (rsp_sum_saturated)
                  saturated_seen++;
               if (rsp_activation_out !== want.act) begin
                  mismatches++;
                  $display("%0t: activation_out mismatch: expected %h actual %h", $time,
                           want.act, rsp_activation_out);
               end
               if (rsp_sum_saturated !== want.sat) begin
                  mismatches++;
                  $display("%0t: sum_saturated mismatch: expected %b actual %b", $time,
                           want.sat, rsp_sum_saturated);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin
      int               seg;
      int               seg_goal;
      int               kind;
      int               len;
      int               k;
      logic [15:0]      rate;
      logic [5:0]       idx;
      logic [31:0]      err;
      snd_pkg::cmd_type op;
      snd_pkg::cmd_type stray;

      // weights: 0 is 1.0, 1 is the most negative, 63 the most positive
      dir_rows = '{
         '{snd_pkg::CMD_LOAD_WEIGHT, 6'd0,  32'h0001_0000, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_LOAD_WEIGHT, 6'd1,  32'h8000_0000, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_LOAD_WEIGHT, 6'd63, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h0000_0000, 32'h0, 1'b1, 1'b1, 16'h8000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd63, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd1,  32'h8000_0000, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd1,  32'h8000_0000, 32'h0, 1'b1, 1'b1, 16'hFFFF, 1'b1},
         '{snd_pkg::CMD_PREDICT,     6'd1,  32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd1,  32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd1,  32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b1},
         '{snd_pkg::CMD_LOAD_BIAS,   6'd5,  32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 16'hFFFF, 1'b1},
         '{snd_pkg::CMD_LOAD_BIAS,   6'd0,  32'h8000_0000, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h8000_0000, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b1},
         '{snd_pkg::CMD_LOAD_BIAS,   6'd0,  32'h0000_0000, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h0005_0000, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h0004_FFFF, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h0002_5FFF, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'hFFFF_0000, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_TRAIN,   6'd0,  32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, 16'h0, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd0,  32'h0001_0000, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{snd_pkg::CMD_TRAIN,   6'd1,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0, 1'b0},
         '{snd_pkg::CMD_TRAIN,   6'd63, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 16'h0, 1'b0},
         '{snd_pkg::CMD_PREDICT,     6'd1,  32'h0001_0000, 32'h0, 1'b1, 1'b0, 16'h0000, 1'b0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 61;
      foreach (dir_rows[r])
         send_beat(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].err,
                   dir_rows[r].last, dir_rows[r].typed, {dir_rows[r].act, dir_rows[r].sat});

      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0, 4:    rate = 16'hFFFF;
            1, 8:    rate = 16'h0000;
            2:       rate = 16'h0001;
            default: rate = 16'($urandom_range(65535));
         endcase
         set_rate(rate);
         if (seg < 4) begin
            send_idle_pct = 6;
            recv_idle_pct = 61;
         end else if (seg < 7) begin
            send_idle_pct = 61;
            recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         seg_goal = beats_sent + SEG_BEATS;
         while (beats_sent < seg_goal) begin
            kind = $urandom_range(99);
            len  = ($urandom_range(24) == 0) ? $urandom_range(64, 7) : $urandom_range(6, 1);
            err  = rand_q16();
            if (kind < 10) begin
               send_beat(snd_pkg::CMD_LOAD_WEIGHT, 6'($urandom_range(63)), rand_q16(),
                         $urandom, 1'($urandom_range(1)));
            end else if (kind < 15) begin
               send_beat(snd_pkg::CMD_LOAD_BIAS, 6'($urandom_range(63)), rand_q16(),
                         $urandom, 1'($urandom_range(1)));
            end else begin
               op    = (kind < 60) ? snd_pkg::CMD_PREDICT : snd_pkg::CMD_TRAIN;
               stray = (kind < 60) ? snd_pkg::CMD_TRAIN : snd_pkg::CMD_PREDICT;
               for (k = 0; k < len; k++) begin
                  idx = 6'($urandom_range(63));
                  // load an unwritten weight before anything reads it
                  if (!weight_written[idx])
                     send_beat(snd_pkg::CMD_LOAD_WEIGHT, idx, rand_q16(), $urandom,
                               1'($urandom_range(1)));
                  // break the vector now and then with a stray beat of the other kind
                  if ($urandom_range(15) == 0)
                     send_beat(stray, idx, rand_q16(), rand_q16(), 1'b0);
                  // drop the last flag on a few vectors so they run into the next
                  send_beat(op, idx, rand_q16(), (op == snd_pkg::CMD_TRAIN) ? err : $urandom,
                            (k == len - 1) && ($urandom_range(19) != 0));
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_activations.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d beats over %0d learning-rate settings, %0d activations checked (%0d saturated)",
               beats_sent, rate_writes + 1, activations_checked, saturated_seen);
      $display("traffic ran sender-idle, receiver-idle and back-to-back in %0d cycles",
               cycle_count);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
